FILE: sv/wavhp_pkg.sv
// Shared types, tags and codes for the WAV header parser.
package wavhp_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] data_length;
    logic [34:0] frame_count;
  } out_word_t;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE   = 3'd1;
  localparam logic [2:0] ST_COMPRESSED = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_NO_FMT     = 3'd4;

  // Chunk tags, first character in the top byte
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] PCM_TAG      = 16'd1;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  // Byte positions inside the file header, chunk header and fmt body
  localparam logic [3:0] HEAD_RIFF_LAST = 4'd3;
  localparam logic [3:0] HEAD_LAST      = 4'd11;
  localparam logic [3:0] CHUNK_TAG_LEN  = 4'd4;
  localparam logic [3:0] CHUNK_LAST     = 4'd7;
  localparam logic [3:0] FMT_LAST       = 4'd15;

  // Quotient bits of the frame-count division
  localparam int unsigned DIV_STEPS = 35;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_HEAD,
    STEP_CHUNK,
    STEP_FMT,
    STEP_SKIP
  } step_t;

  typedef struct packed {
    step_t      step;
    logic       restart;
    logic       load_err;
    logic [2:0] err_code;
    logic       div_start;
    logic       load_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic head_last;
    logic head_tags_ok;
    logic chunk_last;
    logic tag_fmt;
    logic tag_data;
    logic fmt_short;
    logic chunk_empty;
    logic fmt_last;
    logic fmt_pcm;
    logic fmt_no_tail;
    logic fmt_seen;
    logic skip_end;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

FILE: sv/wavhp_top.sv
// WAV header parser: byte-serial RIFF/WAVE header walk with frame-count result.
//
// Input channel (in_valid / in_ready / in_data): one file byte per word, with
// first_byte marking the start of a file (restarts the parse on that byte)
// and end_of_file marking its last byte. Bytes before any first_byte, or
// after a result, are taken and dropped.
// Result channel (out_valid / out_ready / out_data): at most one word per
// file: status plus the fmt fields, data length and frame count, or an error
// status with all other fields zero.
// Throughput: one byte per cycle while parsing and skipping chunks.
// Latency: an error word is valid the cycle after the byte that causes it.
// A good data header starts the frame-count divider, a restoring unit that
// produces one quotient bit a cycle: the word appears once the division is
// done, and in_ready stays low until then.
// Stall: the result sits in an output register; the next byte is still taken
// in the cycle the result drains, and held off while a result is full and
// out_ready is low, and while the divider runs.
// Reset: synchronous, active low; the parser waits for a first_byte and the
// output register is empty.
module wav_header_parser_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wavhp_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wavhp_pkg::out_word_t out_data
);

  wavhp_pkg::dp_cmd_t    cmd;
  wavhp_pkg::dp_status_t sts;

  // Phase sequencing and result decisions
  wavhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_first  (in_data.first_byte),
    .in_eof    (in_data.end_of_file),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // Shifters, held fmt fields, divider and output register
  wavhp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

`ifndef SYNTHESIS
  // No byte is taken while the divider runs
  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !in_ready)
    else $error("byte accepted during frame-count division");

  // A result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_err || cmd.load_ok) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // Good results load only when the quotient is ready
  a_ok_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_ok |-> sts.div_done)
    else $error("good result loaded before division finished");

  // Error words carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != wavhp_pkg::ST_OK) |->
      (out_data.frame_count == '0 && out_data.data_length == '0))
    else $error("error result with nonzero payload");
`endif

endmodule

FILE: sv/wavhp_div.sv
// Restoring divider for the frame count: (length * 8) / divisor, one bit a cycle.
module wavhp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] length_in,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [34:0] quotient
);

  localparam int CW = $clog2(wavhp_pkg::DIV_STEPS + 1);
  localparam logic [CW-1:0] STEPS = CW'(wavhp_pkg::DIV_STEPS);

  logic [34:0]   quo_r, quo_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   dsr_r;
  logic          zero_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [32:0]   rem_sh;

  always_comb begin
    rem_sh = {rem_r[31:0], quo_r[34]};
    if (rem_sh >= {1'b0, dsr_r}) begin
      rem_nxt = rem_sh - {1'b0, dsr_r};
      quo_nxt = {quo_r[33:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[33:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= {length_in, 3'b000};
      rem_r  <= '0;
      dsr_r  <= divisor;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = zero_r ? '0 : quo_r;

endmodule

FILE: sv/wavhp_dp.sv
// Datapath: tag and length shifters, fmt fields, divider and result register.
module wavhp_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wavhp_pkg::in_word_t    in_word,
  input  wavhp_pkg::dp_cmd_t     cmd,
  input  logic                   out_ready,
  output wavhp_pkg::dp_status_t  sts,
  output logic                   out_valid,
  output wavhp_pkg::out_word_t   out_word
);

  logic [3:0]  idx_r, idx_nxt, cur_idx;
  logic [31:0] tag_r, tag_nxt, cur_tag;
  logic [31:0] len_r, len_nxt, cur_len;
  logic [15:0] ftag_r, ftag_nxt, cur_ftag;
  logic [15:0] chan_r, chan_nxt, cur_chan;
  logic [31:0] rate_r, rate_nxt, cur_rate;
  logic [15:0] bits_r, bits_nxt, cur_bits;
  logic        seen_r, seen_nxt, cur_seen;
  logic        out_valid_r;
  wavhp_pkg::out_word_t out_r, res_nxt;

  logic [7:0]  b;
  logic [31:0] tag_new;
  logic [31:0] len_new;
  logic [31:0] chunk_skip;
  logic [31:0] fmt_skip;
  logic        div_done;
  logic [34:0] quotient;

  // A new file starts from cleared state
  assign cur_idx  = cmd.restart ? '0 : idx_r;
  assign cur_tag  = cmd.restart ? '0 : tag_r;
  assign cur_len  = cmd.restart ? '0 : len_r;
  assign cur_ftag = cmd.restart ? '0 : ftag_r;
  assign cur_chan = cmd.restart ? '0 : chan_r;
  assign cur_rate = cmd.restart ? '0 : rate_r;
  assign cur_bits = cmd.restart ? '0 : bits_r;
  assign cur_seen = cmd.restart ? 1'b0 : seen_r;

  assign b       = in_word.file_byte;
  assign tag_new = {cur_tag[23:0], b};

  always_comb begin
    len_new = cur_len;
    unique case (cur_idx[1:0])
      2'd0: len_new[7:0]   = cur_len[7:0]   | b;
      2'd1: len_new[15:8]  = cur_len[15:8]  | b;
      2'd2: len_new[23:16] = cur_len[23:16] | b;
      2'd3: len_new[31:24] = cur_len[31:24] | b;
      default: len_new = cur_len;
    endcase
  end

  // Skip counters hold the padded length minus one
  assign chunk_skip = len_new[0] ? len_new : len_new - 32'd1;
  assign fmt_skip   = cur_len[0] ? cur_len - wavhp_pkg::FMT_BODY_LEN
                                 : cur_len - wavhp_pkg::FMT_BODY_LEN - 32'd1;

  always_comb begin
    idx_nxt  = cur_idx;
    tag_nxt  = cur_tag;
    len_nxt  = cur_len;
    ftag_nxt = cur_ftag;
    chan_nxt = cur_chan;
    rate_nxt = cur_rate;
    bits_nxt = cur_bits;
    seen_nxt = cur_seen;
    unique case (cmd.step)
      wavhp_pkg::STEP_HEAD: begin
        tag_nxt = tag_new;
        if (cur_idx == wavhp_pkg::HEAD_RIFF_LAST) len_nxt = tag_new;
        if (cur_idx == wavhp_pkg::HEAD_LAST) begin
          idx_nxt = '0;
          len_nxt = '0;
        end else begin
          idx_nxt = cur_idx + 4'd1;
        end
      end
      wavhp_pkg::STEP_CHUNK: begin
        if (cur_idx < wavhp_pkg::CHUNK_TAG_LEN) begin
          tag_nxt = tag_new;
          if (cur_idx == '0) len_nxt = '0;
          idx_nxt = cur_idx + 4'd1;
        end else if (cur_idx != wavhp_pkg::CHUNK_LAST) begin
          len_nxt = len_new;
          idx_nxt = cur_idx + 4'd1;
        end else begin
          idx_nxt = '0;
          if (cur_tag == wavhp_pkg::TAG_FMT || cur_tag == wavhp_pkg::TAG_DATA) begin
            len_nxt = len_new;
          end else begin
            len_nxt = chunk_skip;
          end
        end
      end
      wavhp_pkg::STEP_FMT: begin
        unique case (cur_idx)
          4'd0:    ftag_nxt[7:0]   = b;
          4'd1:    ftag_nxt[15:8]  = b;
          4'd2:    chan_nxt[7:0]   = b;
          4'd3:    chan_nxt[15:8]  = b;
          4'd4:    rate_nxt[7:0]   = b;
          4'd5:    rate_nxt[15:8]  = b;
          4'd6:    rate_nxt[23:16] = b;
          4'd7:    rate_nxt[31:24] = b;
          4'd14:   bits_nxt[7:0]   = b;
          4'd15:   bits_nxt[15:8]  = b;
          default: ftag_nxt = cur_ftag;
        endcase
        if (cur_idx == wavhp_pkg::FMT_LAST) begin
          seen_nxt = 1'b1;
          len_nxt  = fmt_skip;
          idx_nxt  = '0;
        end else begin
          idx_nxt = cur_idx + 4'd1;
        end
      end
      wavhp_pkg::STEP_SKIP: begin
        if (cur_len == '0) begin
          idx_nxt = '0;
        end else begin
          len_nxt = cur_len - 32'd1;
        end
      end
      default: idx_nxt = cur_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      seen_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    len_r  <= len_nxt;
    ftag_r <= ftag_nxt;
    chan_r <= chan_nxt;
    rate_r <= rate_nxt;
    bits_r <= bits_nxt;
  end

  wavhp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .length_in (len_new),
    .divisor   (32'(bits_r) * 32'(chan_r)),
    .done      (div_done),
    .quotient  (quotient)
  );

  always_comb begin
    res_nxt = '0;
    if (cmd.load_ok) begin
      res_nxt.status          = wavhp_pkg::ST_OK;
      res_nxt.channel_count   = chan_r;
      res_nxt.sample_rate     = rate_r;
      res_nxt.bits_per_sample = bits_r;
      res_nxt.data_length     = len_r;
      res_nxt.frame_count     = quotient;
    end else begin
      res_nxt.status = cmd.err_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_err || cmd.load_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err || cmd.load_ok) out_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    sts              = '0;
    sts.head_last    = (cur_idx == wavhp_pkg::HEAD_LAST);
    sts.head_tags_ok = (cur_len == wavhp_pkg::TAG_RIFF) && (tag_new == wavhp_pkg::TAG_WAVE);
    sts.chunk_last   = (cur_idx == wavhp_pkg::CHUNK_LAST);
    sts.tag_fmt      = (cur_tag == wavhp_pkg::TAG_FMT);
    sts.tag_data     = (cur_tag == wavhp_pkg::TAG_DATA);
    sts.fmt_short    = (len_new < wavhp_pkg::FMT_BODY_LEN);
    sts.chunk_empty  = (len_new == '0);
    sts.fmt_last     = (cur_idx == wavhp_pkg::FMT_LAST);
    sts.fmt_pcm      = (cur_ftag == wavhp_pkg::PCM_TAG);
    sts.fmt_no_tail  = (cur_len == wavhp_pkg::FMT_BODY_LEN);
    sts.fmt_seen     = cur_seen;
    sts.skip_end     = (cur_len == '0);
    sts.div_done     = div_done;
    sts.out_full     = out_valid_r;
  end

endmodule

FILE: sv/wavhp_ctrl.sv
// Controller: parse phase sequencing, result and division commands.
module wavhp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_first,
  input  logic                  in_eof,
  input  logic                  out_ready,
  input  wavhp_pkg::dp_status_t sts,
  output logic                  in_ready,
  output wavhp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_CHUNK,
    S_FMT,
    S_SKIP,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt, eff;
  logic   accept;
  logic   active;
  logic   hit;
  logic   err;
  logic [2:0] err_code;

  assign in_ready = (state_r != S_DIV) && (!sts.out_full || out_ready);
  assign accept   = in_valid && in_ready;
  assign eff      = in_first ? S_HEAD : state_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.step  = wavhp_pkg::STEP_NONE;
    active    = 1'b0;
    hit       = 1'b0;
    err       = 1'b0;
    err_code  = wavhp_pkg::ST_OK;
    if (state_r == S_DIV) begin
      if (sts.div_done) begin
        cmd.load_ok = 1'b1;
        state_nxt   = S_DONE;
      end
    end else if (accept) begin
      cmd.restart = in_first;
      state_nxt   = eff;
      unique case (eff)
        S_HEAD: begin
          active   = 1'b1;
          cmd.step = wavhp_pkg::STEP_HEAD;
          if (sts.head_last) begin
            if (!sts.head_tags_ok) begin
              err      = 1'b1;
              err_code = wavhp_pkg::ST_NOT_WAVE;
            end else begin
              state_nxt = S_CHUNK;
            end
          end
        end
        S_CHUNK: begin
          active   = 1'b1;
          cmd.step = wavhp_pkg::STEP_CHUNK;
          if (sts.chunk_last) begin
            if (sts.tag_fmt) begin
              if (sts.fmt_short) begin
                err      = 1'b1;
                err_code = wavhp_pkg::ST_TRUNCATED;
              end else begin
                state_nxt = S_FMT;
              end
            end else if (sts.tag_data) begin
              if (!sts.fmt_seen) begin
                err      = 1'b1;
                err_code = wavhp_pkg::ST_NO_FMT;
              end else begin
                // Good header: frame count comes from the divider
                hit           = 1'b1;
                cmd.div_start = 1'b1;
                state_nxt     = S_DIV;
              end
            end else begin
              state_nxt = sts.chunk_empty ? S_CHUNK : S_SKIP;
            end
          end
        end
        S_FMT: begin
          active   = 1'b1;
          cmd.step = wavhp_pkg::STEP_FMT;
          if (sts.fmt_last) begin
            if (!sts.fmt_pcm) begin
              err      = 1'b1;
              err_code = wavhp_pkg::ST_COMPRESSED;
            end else begin
              state_nxt = sts.fmt_no_tail ? S_CHUNK : S_SKIP;
            end
          end
        end
        S_SKIP: begin
          active   = 1'b1;
          cmd.step = wavhp_pkg::STEP_SKIP;
          if (sts.skip_end) state_nxt = S_CHUNK;
        end
        default: active = 1'b0;
      endcase
      // End of file without a result of its own reports truncation
      if (active && !err && !hit && in_eof) begin
        err      = 1'b1;
        err_code = wavhp_pkg::ST_TRUNCATED;
      end
      if (err) begin
        cmd.load_err = 1'b1;
        cmd.err_code = err_code;
        state_nxt    = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
